>>> src/method_lookup_cache_core_macros.svh
// Assertion macros shared by the method lookup cache checker.
`ifndef METHOD_LOOKUP_CACHE_CORE_MACROS_SVH
`define METHOD_LOOKUP_CACHE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("method lookup cache check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("method lookup cache check failed");

`endif

>>> src/mlc_pkg.sv
// Shared types and constants of the method lookup cache.
`default_nettype none
package mlc_pkg;

  localparam int MLC_ENTRIES     = 512;
  localparam int MLC_HANDLE_BITS = 32;

  localparam int FIELD_W     = 32;
  localparam int COUNT_W     = 10;
  localparam int IN_TDATA_W  = 136;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 2;

  localparam logic [COUNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOOKUP    = 2'd0,
    OP_FILL      = 2'd1,
    OP_CLR_METHOD = 2'd2,
    OP_CLR_ORIGIN = 2'd3
  } mlc_op_t;

  typedef enum logic [1:0] {
    RES_HIT_DEF   = 2'd0,
    RES_HIT_UNDEF = 2'd1,
    RES_MISS      = 2'd2,
    RES_DONE      = 2'd3
  } mlc_res_t;

  typedef struct packed {
    logic load;       // capture the input item
    logic idx_step;   // one step of the index remainder
    logic rd_idx;     // read the slot at the index
    logic rd_ptr;     // sweep read at the pointer
    logic fill_wr;    // write a filled slot
    logic wipe_wr;    // reset clearing write at the pointer
    logic ptr_inc;    // advance the pointer
    logic res_lookup; // load a lookup result
    logic res_done;   // load an operation-done result
  } mlc_cmd_t;

  typedef struct packed {
    mlc_op_t op;
    logic    idx_done;
    logic    ptr_last;
    logic    out_free;
  } mlc_sts_t;

endpackage
`default_nettype wire

>>> src/mlc_ctrl.sv
// Controller state machine of the method lookup cache.
`default_nettype none
module mlc_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  mlc_pkg::mlc_sts_t sts,
  output mlc_pkg::mlc_cmd_t cmd
);
  import mlc_pkg::*;

  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_IDX, S_RD, S_CMP, S_FILL, S_SWP, S_SWT, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;
  logic   accept;

  assign in_tready = in_tready_r;
  assign accept    = in_tvalid && in_tready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_WIPE: begin
        cmd.wipe_wr = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (sts.ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = accept;
        if (accept) state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.idx_step = 1'b1;
        if (sts.idx_done) begin
          unique case (sts.op)
            OP_LOOKUP: state_nxt = S_RD;
            OP_FILL:   state_nxt = S_FILL;
            default:   state_nxt = S_SWP;
          endcase
        end
      end
      S_RD: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.res_lookup = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        state_nxt   = S_FIN;
      end
      S_SWP: begin
        cmd.rd_ptr  = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (sts.ptr_last) state_nxt = S_SWT;
      end
      // last sweep compare happens here in the datapath
      S_SWT: state_nxt = S_FIN;
      S_FIN: begin
        cmd.res_done = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE) && !accept;
    end
  end

endmodule
`default_nettype wire

>>> src/mlc_datapath.sv
// Datapath of the method lookup cache: item registers, index unit, slot memory, result register.
`default_nettype none
module mlc_datapath #(
  parameter int ENTRIES     = mlc_pkg::MLC_ENTRIES,
  parameter int HANDLE_BITS = mlc_pkg::MLC_HANDLE_BITS
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  [mlc_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire  [mlc_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [mlc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [mlc_pkg::OUT_TUSER_W-1:0]     out_tuser,
  input  mlc_pkg::mlc_cmd_t                   cmd,
  output mlc_pkg::mlc_sts_t                   sts
);
  import mlc_pkg::*;

  localparam int  KW   = (HANDLE_BITS < FIELD_W) ? HANDLE_BITS : FIELD_W;
  localparam int  IW   = $clog2(ENTRIES);
  localparam int  RW   = IW + 1;
  localparam int  WW   = 2 + 4 * KW;
  localparam bit  POW2 = (ENTRIES & (ENTRIES - 1)) == 0;
  localparam logic [RW-1:0] NMOD  = RW'(ENTRIES);
  localparam logic [IW-1:0] PLAST = IW'(ENTRIES - 1);

  // slot word: valid, undefined, class, id, origin, method
  localparam int B_VAL = 0;
  localparam int B_UND = 1;
  localparam int B_CLS = 2;
  localparam int B_MID = 2 + KW;
  localparam int B_ORG = 2 + 2 * KW;
  localparam int B_MTH = 2 + 3 * KW;

  logic [WW-1:0] mem [ENTRIES];
  logic [WW-1:0] rd_q;

  mlc_op_t       op_r;
  logic [KW-1:0] cls_r, mid_r, org_r, meth_r;
  logic          undef_r;

  logic [FIELD_W-1:0] key_r;
  logic [RW-1:0]      rem_r;
  logic [1:0]         step_r;
  logic [IW-1:0]      idx;

  logic [IW-1:0]      ptr_r;
  logic               chk_r;
  logic [IW-1:0]      chk_addr_r;
  logic [COUNT_W-1:0] cnt_r;

  logic               out_valid_r;
  mlc_res_t           out_res_r;
  logic [FIELD_W-1:0] out_meth_r, out_org_r;
  logic [COUNT_W-1:0] out_cnt_r;

  logic [KW-1:0]      in_cls, in_mid;
  logic [FIELD_W-1:0] key_in;
  logic               hit, sweep_match;
  logic               we;
  logic [IW-1:0]      waddr;
  logic [WW-1:0]      wdata;

  // eight restoring remainder steps, one key byte
  function automatic logic [RW-1:0] rem_step8(input logic [RW-1:0] r_in,
                                              input logic [7:0]    bits);
    logic [RW-1:0] r;
    r = r_in;
    for (int j = 7; j >= 0; j--) begin
      r = {r[RW-2:0], bits[j]};
      if (r >= NMOD) r = r - NMOD;
    end
    return r;
  endfunction

  assign in_cls = in_tdata[KW-1:0];
  assign in_mid = in_tdata[32 +: KW];
  assign key_in = FIELD_W'(in_cls ^ in_mid);
  assign idx    = rem_r[IW-1:0];

  assign sts.op       = op_r;
  assign sts.idx_done = POW2 || (step_r == 2'd3);
  assign sts.ptr_last = (ptr_r == PLAST);
  assign sts.out_free = !out_valid_r || out_tready;

  // item capture and index unit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= mlc_op_t'(in_tuser[1:0]);
      cls_r   <= in_cls;
      mid_r   <= in_mid;
      org_r   <= in_tdata[64 +: KW];
      meth_r  <= in_tdata[96 +: KW];
      undef_r <= in_tdata[128];
      key_r   <= key_in;
      if (POW2) rem_r <= RW'(key_in[IW-1:0]);
      else      rem_r <= '0;
    end else if (cmd.idx_step && !POW2) begin
      rem_r <= rem_step8(rem_r, key_r[FIELD_W-1 -: 8]);
      key_r <= {key_r[FIELD_W-9:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.load) begin
      step_r <= '0;
    end else if (cmd.idx_step) begin
      step_r <= step_r + 2'd1;
    end
  end

  // sweep pointer and compare pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      chk_r <= 1'b0;
    end else begin
      if (cmd.ptr_inc) ptr_r <= (ptr_r == PLAST) ? '0 : ptr_r + 1'b1;
      chk_r <= cmd.rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= ptr_r;
  end

  assign sweep_match = chk_r && rd_q[B_VAL] &&
                       ((op_r == OP_CLR_ORIGIN) ? (rd_q[B_ORG +: KW] == cls_r)
                                                : (rd_q[B_MTH +: KW] == meth_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (sweep_match && cnt_r != CNT_MAX) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // single write port: reset wipe, fill, sweep invalidate
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rd_q;
    if (cmd.wipe_wr) begin
      we    = 1'b1;
      waddr = ptr_r;
      wdata = '0;
    end else if (cmd.fill_wr) begin
      we    = 1'b1;
      waddr = idx;
      wdata = {meth_r, org_r, mid_r, cls_r, undef_r, 1'b1};
    end else if (sweep_match) begin
      we           = 1'b1;
      waddr        = chk_addr_r;
      wdata        = rd_q;
      wdata[B_VAL] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_idx)      rd_q <= mem[idx];
    else if (cmd.rd_ptr) rd_q <= mem[ptr_r];
  end

  assign hit = rd_q[B_VAL] && (rd_q[B_CLS +: KW] == cls_r) && (rd_q[B_MID +: KW] == mid_r);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_lookup || cmd.res_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_lookup) begin
      out_cnt_r <= '0;
      if (hit && !rd_q[B_UND]) begin
        out_res_r  <= RES_HIT_DEF;
        out_meth_r <= FIELD_W'(rd_q[B_MTH +: KW]);
        out_org_r  <= FIELD_W'(rd_q[B_ORG +: KW]);
      end else begin
        out_res_r  <= hit ? RES_HIT_UNDEF : RES_MISS;
        out_meth_r <= '0;
        out_org_r  <= '0;
      end
    end else if (cmd.res_done) begin
      out_res_r  <= RES_DONE;
      out_meth_r <= '0;
      out_org_r  <= '0;
      out_cnt_r  <= cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r;
  assign out_tdata  = {6'b0, out_cnt_r, out_org_r, out_meth_r};

endmodule
`default_nettype wire

>>> src/method_lookup_cache_core.sv
// Top level of the method lookup cache.
`default_nettype none
// Direct-mapped method cache keyed by (class, method id); slot = (class ^ id) mod ENTRIES.
// One item is handled at a time. After reset a clearing pass writes every slot invalid
// while in_tready stays low. When ENTRIES is not a power of two, the index remainder unit
// takes one key byte per step before the slot is read or written. The result sits in
// an output register, so the next item may be taken while it waits. A clear sweep reads
// the slot memory one slot a cycle, with the invalidating write one slot behind the read.
// in_tuser carries the opcode; out_tuser carries the result status.
module method_lookup_cache_core #(
  parameter int ENTRIES     = mlc_pkg::MLC_ENTRIES,
  parameter int HANDLE_BITS = mlc_pkg::MLC_HANDLE_BITS
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // [31:0] class_ref, [63:32] method_id, [95:64] fill_origin, [127:96] method_ref,
  // [128] fill_undefined, [135:129] zero
  input  wire  [mlc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] opcode
  input  wire  [mlc_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [31:0] found_method, [63:32] found_origin, [73:64] cleared_count, [79:74] zero
  output logic [mlc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [mlc_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import mlc_pkg::*;

  mlc_cmd_t cmd;
  mlc_sts_t sts;

  mlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlc_datapath #(
    .ENTRIES     (ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

>>> src/mlc_checker.sv
// Port-level checks of the method lookup cache, bound to the top level.
`default_nettype none
`include "method_lookup_cache_core_macros.svh"
module mlc_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [mlc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire [mlc_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import mlc_pkg::*;

  // a stalled result holds
  `MLC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // one item at a time: ready drops after an accepted item
  `MLC_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)
  // lookups never report a cleared count
  `MLC_ASSERT_NOW(a_lookup_no_count, out_tvalid && out_tuser != RES_DONE, out_tdata[73:64] == '0)
  // method and origin only on a defined hit
  `MLC_ASSERT_NOW(a_found_zero, out_tvalid && out_tuser != RES_HIT_DEF, out_tdata[63:0] == '0)

endmodule

bind method_lookup_cache_core mlc_checker u_mlc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

>>> bench/method_lookup_cache_checker.sv
// Checker for the method lookup cache: predicts each reply and compares it with the block.
module method_lookup_cache_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  input  wire                                in_tready,
  // [31:0] class_ref, [63:32] method_id, [95:64] fill_origin, [127:96] method_ref,
  // [128] fill_undefined, [135:129] zero
  input  wire [mlc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] opcode
  input  wire [mlc_pkg::IN_TUSER_W-1:0]      in_tuser,
  input  wire                                out_tvalid,
  input  wire                                out_tready,
  // [31:0] found_method, [63:32] found_origin, [73:64] cleared_count, [79:74] zero
  input  wire [mlc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [1:0] status
  input  wire [mlc_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output int unsigned                        fail_count,
  output int unsigned                        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import mlc_pkg::*;

  typedef struct packed {
    mlc_res_t           status;
    logic [FIELD_W-1:0] method;
    logic [FIELD_W-1:0] origin;
    logic [COUNT_W-1:0] cleared;
  } cache_reply_t;

  // Shadow of the slot table; contents only read where the valid mark is set.
  logic               slot_valid  [MLC_ENTRIES];
  logic [FIELD_W-1:0] slot_class  [MLC_ENTRIES];
  logic [FIELD_W-1:0] slot_id     [MLC_ENTRIES];
  logic [FIELD_W-1:0] slot_origin [MLC_ENTRIES];
  logic [FIELD_W-1:0] slot_method [MLC_ENTRIES];
  logic               slot_undef  [MLC_ENTRIES];

  cache_reply_t reply_q[$];

  // Handles are full 32 bits here, so no masking to HANDLE_BITS is needed.
  function automatic cache_reply_t resolve_item(mlc_op_t op, logic [FIELD_W-1:0] cls,
                                                logic [FIELD_W-1:0] mid,
                                                logic [FIELD_W-1:0] org,
                                                logic [FIELD_W-1:0] meth, logic undef);
    cache_reply_t       r;
    int unsigned        s;
    logic [FIELD_W-1:0] key;
    r = '0;
    r.status = RES_DONE;
    s = (cls ^ mid) % MLC_ENTRIES;
    case (op)
      OP_LOOKUP: begin
        if (slot_valid[s] && slot_class[s] == cls && slot_id[s] == mid) begin
          if (slot_undef[s]) begin
            r.status = RES_HIT_UNDEF;
          end else begin
            r.status = RES_HIT_DEF;
            r.method = slot_method[s];
            r.origin = slot_origin[s];
          end
        end else begin
          r.status = RES_MISS;
        end
      end
      OP_FILL: begin
        slot_valid[s]  = 1'b1;
        slot_class[s]  = cls;
        slot_id[s]     = mid;
        slot_origin[s] = org;
        slot_method[s] = meth;
        slot_undef[s]  = undef;
      end
      default: begin
        key = (op == OP_CLR_ORIGIN) ? cls : meth;
        for (int i = 0; i < MLC_ENTRIES; i++) begin
          if (slot_valid[i] &&
              ((op == OP_CLR_ORIGIN) ? slot_origin[i] : slot_method[i]) == key) begin
            slot_valid[i] = 1'b0;
            if (r.cleared != CNT_MAX) r.cleared++;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string what, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $display("%t: %s expected %h got %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cache_reply_t want;
    cache_reply_t got;
    if (!rst_n) begin
      for (int i = 0; i < MLC_ENTRIES; i++) slot_valid[i] = 1'b0;
      reply_q.delete();
      pending_count = 0;
    end else begin
      // replies are registered, so retire before taking the new item
      if (out_tvalid && out_tready) begin
        got.status  = mlc_res_t'(out_tuser);
        got.method  = out_tdata[31:0];
        got.origin  = out_tdata[63:32];
        got.cleared = out_tdata[73:64];
        if (reply_q.size() == 0) begin
          $display("%t: reply expected none got status %h data %h", $time, out_tuser,
                   out_tdata);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          pending_count--;
          check_field("status", FIELD_W'(want.status), FIELD_W'(got.status));
          check_field("found_method", want.method, got.method);
          check_field("found_origin", want.origin, got.origin);
          check_field("cleared_count", FIELD_W'(want.cleared), FIELD_W'(got.cleared));
        end
      end
      if (in_tvalid && in_tready) begin
        reply_q.push_back(resolve_item(mlc_op_t'(in_tuser), in_tdata[31:0], in_tdata[63:32],
                                       in_tdata[95:64], in_tdata[127:96], in_tdata[128]));
        pending_count++;
      end
    end
  end

endmodule

>>> bench/method_lookup_cache_core_tb.sv
// Testbench top for the method lookup cache: stimulus, receiver stalls, watchdog, verdict.
module method_lookup_cache_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlc_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 1530;
  localparam int FLOOD_AT     = 400;
  localparam int DRAIN_EVERY  = 350;
  localparam int KEY_POOL     = 48;
  localparam int HANDLE_POOL  = 8;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_pattern_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned quiet_cycles = 0;

  rx_pattern_t rx_pattern = RX_OPEN;
  int unsigned rx_left    = 0;

  logic [31:0] key_class [KEY_POOL];
  logic [31:0] key_id    [KEY_POOL];
  logic [31:0] meth_pool [HANDLE_POOL];
  logic [31:0] org_pool  [HANDLE_POOL];
  logic [31:0] flood_meth;
  logic [31:0] flood_org;

  method_lookup_cache_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  method_lookup_cache_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: switch to a new random stall pattern whenever rx_left runs out.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
      rx_left    <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_pattern)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= (rx_left % 8) < 5;
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Returns at the rising edge that accepts the item; tvalid stays high.
  task automatic send_item(mlc_op_t op, logic [31:0] cls, logic [31:0] mid,
                           logic [31:0] org, logic [31:0] meth, logic undef);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, undef, meth, org, mid, cls};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic hold_off(int unsigned cycles, bit drain);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
    if (drain) while (pending_count != 0) @(negedge clk);
  endtask

  task automatic pick_key(output logic [31:0] cls, output logic [31:0] mid);
    int unsigned k;
    int unsigned r;
    logic [31:0] a;
    k   = $urandom_range(0, KEY_POOL - 1);
    r   = $urandom_range(0, 19);
    a   = $urandom;
    cls = key_class[k];
    mid = key_id[k];
    if (r == 0) begin
      mid = mid ^ (a << 9);      // same slot and class, other id
    end else if (r == 1) begin
      cls = cls ^ a;             // same slot, other tag
      mid = mid ^ a;
    end else if (r < 4) begin
      cls = $urandom;
      mid = a;
    end
  endtask

  task automatic send_random_item(int unsigned n);
    int unsigned r;
    logic [31:0] cls;
    logic [31:0] mid;
    logic [31:0] org;
    logic [31:0] meth;
    r = $urandom_range(0, 99);
    pick_key(cls, mid);
    org  = ($urandom_range(0, 4) != 0) ? org_pool[$urandom_range(0, HANDLE_POOL - 1)]
                                       : $urandom;
    meth = ($urandom_range(0, 4) != 0) ? meth_pool[$urandom_range(0, HANDLE_POOL - 1)]
                                       : $urandom;
    if (n >= FLOOD_AT && n < FLOOD_AT + MLC_ENTRIES) begin
      // fill every slot once with one method, then sweep them all
      cls = $urandom;
      send_item(OP_FILL, cls, cls ^ 32'(n - FLOOD_AT), flood_org, flood_meth,
                1'($urandom_range(0, 1)));
    end else if (n == FLOOD_AT + MLC_ENTRIES) begin
      send_item(OP_CLR_METHOD, cls, mid, org, flood_meth, 1'($urandom_range(0, 1)));
    end else if (r < 45) begin
      send_item(OP_LOOKUP, cls, mid, org, meth, 1'($urandom_range(0, 1)));
    end else if (r < 86) begin
      send_item(OP_FILL, cls, mid, org, meth, $urandom_range(0, 4) == 0);
    end else if (r < 93) begin
      send_item(OP_CLR_METHOD, cls, mid, $urandom, meth, 1'($urandom_range(0, 1)));
    end else begin
      send_item(OP_CLR_ORIGIN, org, mid, $urandom, meth, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned burst;
    int unsigned gap;
    int unsigned guard;
    for (int i = 0; i < KEY_POOL; i++) begin
      key_class[i] = $urandom;
      key_id[i]    = $urandom;
    end
    for (int i = 0; i < HANDLE_POOL; i++) begin
      meth_pool[i] = $urandom;
      org_pool[i]  = $urandom;
    end
    flood_meth = $urandom;
    flood_org  = $urandom;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every op, overwrite, tag aliasing, empty sweeps
    send_item(OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_item(OP_FILL, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_item(OP_LOOKUP, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
    send_item(OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_item(OP_FILL, 32'hFFFF_FFFF, 32'h0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0200, 32'h0, 32'h0, 1'b0);
    send_item(OP_FILL, 32'h1234_5678, 32'h9ABC_DEF0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
    send_item(OP_FILL, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h5A5A_5A5A, 1'b1);
    send_item(OP_CLR_METHOD, 32'h0, 32'h0, 32'h0, 32'h5A5A_5A5A, 1'b0);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
    send_item(OP_CLR_METHOD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h5A5A_5A5A, 1'b1);
    send_item(OP_FILL, 32'h7, 32'h3, 32'hDEAD_BEEF, 32'h1, 1'b0);
    send_item(OP_FILL, 32'h8, 32'h3, 32'hDEAD_BEEF, 32'h2, 1'b0);
    send_item(OP_CLR_ORIGIN, 32'hDEAD_BEEF, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_item(OP_CLR_ORIGIN, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
    send_item(OP_CLR_ORIGIN, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_item(OP_LOOKUP, 32'h8, 32'h3, 32'h0, 32'h0, 1'b0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      for (int b = 0; b < burst && n < RANDOM_ITEMS; b++) begin
        if (n > 0 && n % DRAIN_EVERY == 0) hold_off(1, 1'b1);
        send_random_item(n);
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) hold_off(gap, 1'b0);
    end

    hold_off(1, 1'b0);
    guard = 0;
    while (pending_count != 0 && guard < IDLE_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      if (pending_count != 0) $display("%t: %0d replies never arrived", $time, pending_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/mlc_pkg.sv
src/mlc_ctrl.sv
src/mlc_datapath.sv
src/method_lookup_cache_core.sv
src/mlc_checker.sv
bench/method_lookup_cache_checker.sv
bench/method_lookup_cache_core_tb.sv
